// File: design/sha1bs_pkg.sv
`default_nettype none
package sha1bs_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int ROUNDS = 80;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;

  typedef enum logic [1:0] {
    OP_BYTE     = 2'd0,
    OP_BYTE_END = 2'd1,
    OP_END      = 2'd2
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } queue_wr_t;

  typedef struct packed {
    logic   avail;
    entry_t entry;
  } queue_rd_t;

  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0:    v = 32'h67452301;
      3'd1:    v = 32'hEFCDAB89;
      3'd2:    v = 32'h98BADCFE;
      3'd3:    v = 32'h10325476;
      default: v = 32'hC3D2E1F0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_const(input logic [6:0] t);
    logic [31:0] k;
    if (t < 7'd20)      k = 32'h5A827999;
    else if (t < 7'd40) k = 32'h6ED9EBA1;
    else if (t < 7'd60) k = 32'h8F1BBCDC;
    else                k = 32'hCA62C1D6;
    return k;
  endfunction

  function automatic logic [31:0] round_fn(input logic [6:0] t, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (t < 7'd20)                     f = (b & c) | (~b & d);
    else if (t >= 7'd40 && t < 7'd60)  f = (b & c) | (b & d) | (c & d);
    else                               f = b ^ c ^ d;
    return f;
  endfunction

endpackage
`default_nettype wire

// File: design/sha1bs_front.sv
`default_nettype none
module sha1bs_front (
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [7:0]             data_byte,
  input  wire logic                   has_byte,
  input  wire logic                   end_of_message,
  input  wire logic                   full,
  output sha1bs_pkg::queue_wr_t       wr
);

  sha1bs_pkg::op_t op;

  always_comb begin
    unique case ({has_byte, end_of_message})
      2'b11:   op = sha1bs_pkg::OP_BYTE_END;
      2'b01:   op = sha1bs_pkg::OP_END;
      default: op = sha1bs_pkg::OP_BYTE;
    endcase
  end

  assign in_stall       = full;
  // drop items that carry neither a byte nor the end mark
  assign wr.push        = in_valid && !full && (has_byte || end_of_message);
  assign wr.entry.op    = op;
  assign wr.entry.data  = data_byte;

endmodule
`default_nettype wire

// File: design/sha1bs_queue.sv
`default_nettype none
module sha1bs_queue #(
  parameter int DEPTH = sha1bs_pkg::QUEUE_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire sha1bs_pkg::queue_wr_t  wr,
  output logic                        full,
  output sha1bs_pkg::queue_rd_t       rd,
  input  wire logic                   pop
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  sha1bs_pkg::entry_t mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full     = count == CNT_W'(DEPTH);
  assign rd.avail = count != '0;
  assign rd.entry = mem[rptr];
  assign do_pop   = pop && rd.avail;

  always_ff @(posedge clk) begin
    if (wr.push) begin
      mem[wptr] <= wr.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr.push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CNT_W'(wr.push) - CNT_W'(do_pop);
    end
  end

endmodule
`default_nettype wire

// File: design/sha1bs_core.sv
`default_nettype none
module sha1bs_core (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire sha1bs_pkg::queue_rd_t  rd,
  output logic                        pop,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [31:0]                 digest_word,
  output logic [2:0]                  word_index,
  output logic                        last_word
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_PAD_MARK = 7'b0000010,
    S_PAD_ZERO = 7'b0000100,
    S_PAD_LEN  = 7'b0001000,
    S_ROUND    = 7'b0010000,
    S_FOLD     = 7'b0100000,
    S_EMIT     = 7'b1000000
  } state_t;

  localparam logic [6:0] LAST_ROUND = 7'(sha1bs_pkg::ROUNDS - 1);

  state_t       state;
  state_t       ret;
  state_t       after_put;
  logic [31:0]  chain [5];
  logic [31:0]  a, b, c, d, e;
  logic [511:0] sched;
  logic [63:0]  len;
  logic [5:0]   fill_pos;
  logic [6:0]   rnd;
  logic [2:0]   widx;

  logic         put;
  logic [7:0]   put_data;
  logic [31:0]  w0;
  logic [31:0]  wx;
  logic [31:0]  w_new;
  logic [31:0]  tmp;
  logic         out_take;

  assign w0    = sched[511:480];
  assign wx    = sched[95:64] ^ sched[255:224] ^ sched[447:416] ^ w0;
  assign w_new = {wx[30:0], wx[31]};
  assign tmp   = {a[26:0], a[31:27]} + sha1bs_pkg::round_fn(rnd, b, c, d) + e
               + sha1bs_pkg::round_const(rnd) + w0;

  assign pop      = (state == S_IDLE) && rd.avail;
  assign out_valid = state == S_EMIT;
  assign out_take  = out_valid && !out_stall;
  assign word_index = widx;
  assign last_word  = widx == 3'd4;

  always_comb begin
    case (widx)
      3'd0:    digest_word = chain[0];
      3'd1:    digest_word = chain[1];
      3'd2:    digest_word = chain[2];
      3'd3:    digest_word = chain[3];
      default: digest_word = chain[4];
    endcase
  end

  always_comb begin
    put       = 1'b0;
    put_data  = rd.entry.data;
    after_put = S_IDLE;
    unique case (state)
      S_IDLE: begin
        put       = rd.avail && (rd.entry.op != sha1bs_pkg::OP_END);
        after_put = (rd.entry.op == sha1bs_pkg::OP_BYTE) ? S_IDLE : S_PAD_MARK;
      end
      S_PAD_MARK: begin
        put       = 1'b1;
        put_data  = sha1bs_pkg::PAD_MARK;
        after_put = S_PAD_ZERO;
      end
      S_PAD_ZERO: begin
        put       = fill_pos != sha1bs_pkg::LEN_POS;
        put_data  = 8'h00;
        after_put = S_PAD_ZERO;
      end
      S_PAD_LEN: begin
        put       = 1'b1;
        put_data  = len[63:56];
        after_put = S_PAD_LEN;
      end
      default: begin
        put       = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (put) begin
      sched <= {sched[503:0], put_data};
    end else if (state == S_ROUND) begin
      sched <= {sched[479:0], w_new};
    end
    if (put && (&fill_pos)) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (state == S_ROUND) begin
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= tmp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ret      <= S_IDLE;
      len      <= '0;
      fill_pos <= '0;
      rnd      <= '0;
      widx     <= '0;
      for (int i = 0; i < 5; i++) begin
        chain[i] <= sha1bs_pkg::iv_word(3'(i));
      end
    end else begin
      if (put) begin
        fill_pos <= fill_pos + 1'b1;
        if (&fill_pos) begin
          state <= S_ROUND;
          rnd   <= '0;
          ret   <= (state == S_PAD_LEN) ? S_EMIT : after_put;
        end else begin
          state <= after_put;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (rd.avail && rd.entry.op == sha1bs_pkg::OP_END) begin
            state <= S_PAD_MARK;
          end
          if (put) begin
            len <= len + 64'd8;
          end
        end
        S_PAD_MARK: begin
        end
        S_PAD_ZERO: begin
          if (!put) begin
            state   <= S_PAD_LEN;
          end
        end
        S_PAD_LEN: begin
          // shift out the length; it ends at zero, ready for the next message
          len     <= {len[55:0], 8'h00};
        end
        S_ROUND: begin
          rnd <= rnd + 1'b1;
          if (rnd == LAST_ROUND) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          chain[0] <= chain[0] + a;
          chain[1] <= chain[1] + b;
          chain[2] <= chain[2] + c;
          chain[3] <= chain[3] + d;
          chain[4] <= chain[4] + e;
          rnd      <= '0;
          state    <= ret;
        end
        S_EMIT: begin
          if (out_take) begin
            if (last_word) begin
              widx  <= '0;
              state <= S_IDLE;
              for (int i = 0; i < 5; i++) begin
                chain[i] <= sha1bs_pkg::iv_word(3'(i));
              end
            end else begin
              widx <= widx + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/sha1_byte_stream_hasher_top.sv
// SHA-1 hasher fed one byte per request; end_of_message closes the message (with or
// without a byte) and the five digest words follow as five requests, h0 first. Requests
// enter a four-entry queue at up to one per cycle while it is not full, and the hash
// engine drains it one byte per cycle while in its idle state; each full 64-byte block
// then passes through 80 rounds of the single round unit and a fold step. An end
// request without a byte adds no byte to the block. Padding is then written one byte per
// cycle, apart from any compression: the 0x80 mark, 0 to 63 zero bytes, a step that
// switches to the length, and the eight length bytes. The compression of the last block
// follows. When the mark lands at byte 56 or later, the block is also compressed after
// byte 63, and 56 zero bytes follow before the length. The digest words then leave one
// per cycle while the output is not stalled.
`default_nettype none
module sha1_byte_stream_hasher_top #(
  parameter int QUEUE_DEPTH = sha1bs_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        has_byte,
  input  wire logic        end_of_message,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);

  sha1bs_pkg::queue_wr_t wr;
  sha1bs_pkg::queue_rd_t rd;
  logic                  full;
  logic                  pop;

  sha1bs_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .has_byte       (has_byte),
    .end_of_message (end_of_message),
    .full           (full),
    .wr             (wr)
  );

  sha1bs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (wr),
    .full (full),
    .rd   (rd),
    .pop  (pop)
  );

  sha1bs_core u_core (
    .clk         (clk),
    .rst         (rst),
    .rd          (rd),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

endmodule
`default_nettype wire

// File: design/sha1bs_checker.sv
`default_nettype none
module sha1bs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] digest_word,
  input wire logic [2:0]  word_index,
  input wire logic        last_word
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(digest_word) && $stable(word_index))
    else $error("stalled digest request changed");

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_index == 3'd4)) && (word_index <= 3'd4))
    else $error("last_word does not match word_index");

  a_next: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_word |=>
      out_valid && (word_index == $past(word_index) + 3'd1))
    else $error("digest words not sent in sequence");

  a_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_word |=> !out_valid)
    else $error("digest continued past last word");

endmodule

bind sha1_byte_stream_hasher_top sha1bs_checker u_chk (.*);
`default_nettype wire

// File: tb/tb.sv
`default_nettype none
module tb;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int ITEM_TARGET = 460;
  localparam int DRAIN_CYCLES = 300;
  localparam logic [4:0][31:0] SHA1_IV = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };
  localparam logic [31:0] K_CH = 32'h5A827999;
  localparam logic [31:0] K_PAR1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
  localparam logic [31:0] K_PAR2 = 32'hCA62C1D6;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        has_byte = 1'b0;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  logic [31:0]  chain_value [5];
  logic [31:0]  block_words [16];
  logic [63:0]  bit_count;
  digest_word_t due_words [64];
  logic [5:0]   due_head = '0;
  logic [5:0]   due_tail = '0;
  digest_word_t due_word;
  int           errors = 0;
  int           items_sent = 0;
  int           rx_hold_cycles = 0;
  bit           tx_quiet = 1'b0;
  bit           rx_quiet = 1'b0;

  sha1_byte_stream_hasher_top uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .has_byte(has_byte),
    .end_of_message(end_of_message),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .digest_word(digest_word),
    .word_index(word_index),
    .last_word(last_word)
  );

  always #1 clk = ~clk;

  function automatic int idle_len(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void start_message();
    int i;
    for (i = 0; i < 5; i++) chain_value[i] = SHA1_IV[i];
    bit_count = '0;
  endfunction

  function automatic void compress_chunk();
    logic [31:0] a, b, c, d, e, f, k, w, sum;
    int t;
    a = chain_value[0];
    b = chain_value[1];
    c = chain_value[2];
    d = chain_value[3];
    e = chain_value[4];
    for (t = 0; t < sha1bs_pkg::ROUNDS; t++) begin
      if (t >= 16) begin
        w = block_words[(t + 13) & 15] ^ block_words[(t + 8) & 15]
          ^ block_words[(t + 2) & 15] ^ block_words[t & 15];
        w = {w[30:0], w[31]};
        block_words[t & 15] = w;
      end else begin
        w = block_words[t];
      end
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = K_CH;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = K_PAR1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_MAJ;
      end else begin
        f = b ^ c ^ d;
        k = K_PAR2;
      end
      sum = {a[26:0], a[31:27]} + f + e + k + w;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = sum;
    end
    chain_value[0] += a;
    chain_value[1] += b;
    chain_value[2] += c;
    chain_value[3] += d;
    chain_value[4] += e;
  endfunction

  function automatic void pack_byte(input logic [5:0] pos, input logic [7:0] b);
    block_words[pos[5:2]] = {block_words[pos[5:2]][23:0], b};
    if (pos == 6'd63) compress_chunk();
  endfunction

  function automatic void absorb_request(input logic [7:0] b, input logic hb,
                                         input logic eom);
    logic [5:0] pos;
    digest_word_t dw;
    int i;
    if (hb) begin
      pos = bit_count[8:3];
      bit_count += 64'd8;
      pack_byte(pos, b);
    end
    if (!eom) return;
    pos = bit_count[8:3];
    pack_byte(pos, sha1bs_pkg::PAD_MARK);
    pos++;
    while (pos != sha1bs_pkg::LEN_POS) begin
      pack_byte(pos, 8'h00);
      pos++;
    end
    for (i = 7; i >= 0; i--) begin
      pack_byte(pos, bit_count[i*8 +: 8]);
      pos++;
    end
    for (i = 0; i < 5; i++) begin
      dw.word = chain_value[i];
      dw.idx = 3'(i);
      dw.last = (i == 4);
      due_words[due_tail] = dw;
      due_tail++;
    end
    start_message();
  endfunction

  task automatic send_request(input logic [7:0] b, input logic hb, input logic eom);
    int gap;
    gap = idle_len(tx_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    has_byte <= hb;
    end_of_message <= eom;
    do @(posedge clk); while (in_stall !== 1'b0);
    absorb_request(b, hb, eom);
    if (hb || eom) items_sent++;
  endtask

  task automatic send_message(input int len, input bit end_on_byte);
    int i;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) send_request(8'($urandom), 1'b0, 1'b0);
      send_request(8'($urandom), 1'b1, end_on_byte && i == len - 1);
    end
    if (!end_on_byte || len == 0) send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  function automatic int random_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 6);
    if (r < 85) return $urandom_range(50, 70);
    if (r < 95) return $urandom_range(7, 49);
    return $urandom_range(110, 130);
  endfunction

  task automatic test_empty_message();
    send_request(8'hFF, 1'b0, 1'b1);
  endtask

  task automatic test_short_messages();
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);
    send_request(8'hFF, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'h80, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_ignored_requests();
    send_request(8'hFF, 1'b0, 1'b0);
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'hA5, 1'b1, 1'b0);
    send_request(8'h5A, 1'b0, 1'b0);
    send_request(8'hC3, 1'b0, 1'b1);
  endtask

  task automatic test_pad_boundaries();
    send_message(55, 1'($urandom_range(0, 1)));
    send_message(56, 1'($urandom_range(0, 1)));
    send_message(63, 1'b1);
    send_message(63, 1'b0);
    send_message(64, 1'($urandom_range(0, 1)));
  endtask

  task automatic test_input_backpressure();
    int i;
    tx_quiet = 1'b1;
    rx_hold_cycles = 500;
    for (i = 0; i < 6; i++) send_message(3, i[0]);
    tx_quiet = 1'b0;
  endtask

  task automatic test_back_to_back();
    int i;
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    for (i = 0; i < 4; i++) begin
      send_message($urandom_range(0, 9), 1'($urandom_range(0, 1)));
    end
    send_message(60, 1'b1);
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  task automatic test_random_messages();
    int len;
    while (items_sent < ITEM_TARGET) begin
      len = random_length();
      if (len > ITEM_TARGET - items_sent) len = ITEM_TARGET - items_sent;
      send_message(len, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin : rx_pacing
    int n;
    @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        n = rx_hold_cycles;
        rx_hold_cycles = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end else begin
        n = idle_len(rx_quiet);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (due_head == due_tail) begin
        $error("unexpected digest word %h index %0d", digest_word, word_index);
        errors++;
      end else begin
        due_word = due_words[due_head];
        due_head++;
        if (digest_word !== due_word.word) begin
          $error("digest_word: expected %h, got %h", due_word.word, digest_word);
          errors++;
        end
        if (word_index !== due_word.idx) begin
          $error("word_index: expected %0d, got %0d", due_word.idx, word_index);
          errors++;
        end
        if (last_word !== due_word.last) begin
          $error("last_word: expected %0b, got %0b", due_word.last, last_word);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("sha1_byte_stream_hasher_top regression: fail");
    $finish;
  end

  initial begin
    for (int i = 0; i < 16; i++) block_words[i] = '0;
    start_message();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_message();
    test_short_messages();
    test_ignored_requests();
    test_pad_boundaries();
    test_input_backpressure();
    test_back_to_back();
    test_random_messages();
    in_valid <= 1'b0;
    while (due_head != due_tail) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("sha1_byte_stream_hasher_top regression: pass");
    end else begin
      $display("sha1_byte_stream_hasher_top regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
